@@ sv/signed_integer_to_radix_digits_core_assert.svh @@
// ============================================================================
// Assertion macros for the radix digit converter
// Shared wrappers for concurrent assertions, clocked on clk and disabled in reset.
// ============================================================================
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_ASSERT_SVH

// Same-cycle implication.
`define SIRD_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SIRD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sird_pkg.sv @@
// ============================================================================
// Radix digit converter package
// Widths, register indexes, command and status types, and radix tables.
// ============================================================================
package sird_pkg;

    localparam int VALUE_W     = 32;
    localparam int SYMBOL_W    = 8;
    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = 5;
    localparam int COUNT_W     = 6;
    localparam int IDX_W       = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int MAX_RADIX   = 16;
    localparam int MAX_DIGITS  = 32;

    localparam logic [SYMBOL_W-1:0] MINUS_SIGN = 8'h2D;

    localparam logic [CFG_INDEX_W-1:0] REG_RADIX        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic fix;
        logic push_sign;
        logic push_digit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic q_next_zero;
        logic cnt_next_full;
        logic negative;
        logic last_digit;
        logic out_free;
    } sts_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] c;
        c = r;
        if (r < RADIX_W'(2))
        begin
            c = RADIX_W'(2);
        end
        else if (r > RADIX_W'(MAX_RADIX))
        begin
            c = RADIX_W'(MAX_RADIX);
        end
        return c;
    endfunction

    // floor(2^32 / r). The estimate it gives is never high and at most one low.
    function automatic logic [VALUE_W-1:0] reciprocal(input logic [RADIX_W-1:0] r);
        logic [VALUE_W-1:0] m;
        case (r)
            5'd2:    m = 32'h8000_0000;
            5'd3:    m = 32'h5555_5555;
            5'd4:    m = 32'h4000_0000;
            5'd5:    m = 32'h3333_3333;
            5'd6:    m = 32'h2AAA_AAAA;
            5'd7:    m = 32'h2492_4924;
            5'd8:    m = 32'h2000_0000;
            5'd9:    m = 32'h1C71_C71C;
            5'd10:   m = 32'h1999_9999;
            5'd11:   m = 32'h1745_D174;
            5'd12:   m = 32'h1555_5555;
            5'd13:   m = 32'h13B1_3B13;
            5'd14:   m = 32'h1249_2492;
            5'd15:   m = 32'h1111_1111;
            5'd16:   m = 32'h1000_0000;
            default: m = 32'h8000_0000;
        endcase
        return m;
    endfunction

endpackage

@@ sv/sird_if.sv @@
// ============================================================================
// Radix digit converter channels
// Valid/ready channels for the input integer and the output symbols.
// ============================================================================
interface sird_value_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sird_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sird_symbol_if;
    logic                           valid;
    logic                           ready;
    logic [sird_pkg::SYMBOL_W-1:0]  symbol;
    logic                           last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

@@ sv/sird_ctrl.sv @@
// ============================================================================
// Radix digit converter controller
// Sequences load, digit extraction and most-significant-first emission.
// ============================================================================
module sird_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sird_pkg::sts_t  sts,
    output sird_pkg::cmd_t  cmd
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                // The first pass always runs, so zero yields its single digit.
                cmd.fix = 1'b1;
                if (sts.q_next_zero || sts.cnt_next_full)
                begin
                    state_next = sts.negative ? ST_SIGN : ST_EMIT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_SIGN:
            begin
                if (sts.out_free)
                begin
                    cmd.push_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.push_digit = 1'b1;
                    if (sts.last_digit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/sird_datapath.sv @@
// ============================================================================
// Radix digit converter datapath
// Configuration registers, reciprocal divider, digit store and output register.
// ============================================================================
`include "signed_integer_to_radix_digits_core_assert.svh"

module sird_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [sird_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sird_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [sird_pkg::VALUE_W-1:0]  value,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [sird_pkg::SYMBOL_W-1:0]        out_symbol,
    output logic                                 out_last,
    input  sird_pkg::cmd_t                       cmd,
    output sird_pkg::sts_t                       sts
);

    localparam int VW = sird_pkg::VALUE_W;
    localparam int RW = sird_pkg::RADIX_W;
    localparam int CW = sird_pkg::COUNT_W;
    localparam int IW = sird_pkg::IDX_W;
    localparam int DW = sird_pkg::DIGIT_W;
    localparam int SW = sird_pkg::SYMBOL_W;

    logic [RW-1:0]                   radix_cfg_reg;
    logic [sird_pkg::CFG_DATA_W-1:0] symbols_low_reg;
    logic [sird_pkg::CFG_DATA_W-1:0] symbols_high_reg;

    logic [VW-1:0]  quotient_reg;
    logic [VW-1:0]  prod_hi_reg;
    logic [VW-1:0]  recip_reg;
    logic [RW-1:0]  radix_reg;
    logic [CW-1:0]  count_reg;
    logic           negative_reg;
    logic [DW-1:0]  digit_store [sird_pkg::MAX_DIGITS];

    logic           out_valid_reg;
    logic [SW-1:0]  out_symbol_reg;
    logic           out_last_reg;

    logic [VW-1:0]     value_u;
    logic [VW-1:0]     magnitude;
    logic [RW-1:0]     radix_eff;
    logic [2*VW-1:0]   product;
    logic [2*RW-1:0]   q_times_r;
    logic [RW-1:0]     rem_est;
    logic              rem_over;
    logic [RW-1:0]     rem_fix;
    logic [VW-1:0]     q_new;
    logic [CW-1:0]     count_inc;
    logic [CW-1:0]     count_dec;
    logic [IW-1:0]     rd_idx;
    logic [2*sird_pkg::CFG_DATA_W-1:0] symbol_table;
    logic              out_free;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_cfg_reg    <= sird_pkg::RADIX_RESET;
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sird_pkg::REG_RADIX:        radix_cfg_reg    <= cfg_data[RW-1:0];
                sird_pkg::REG_SYMBOLS_LOW:  symbols_low_reg  <= cfg_data;
                sird_pkg::REG_SYMBOLS_HIGH: symbols_high_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign value_u   = value;
    assign magnitude = value_u[VW-1] ? (VW'(0) - value_u) : value_u;
    assign radix_eff = sird_pkg::clamp_radix(radix_cfg_reg);

    assign product = {{VW{1'b0}}, quotient_reg} * {{VW{1'b0}}, recip_reg};

    // The estimated quotient is exact or one low, so the estimated remainder
    // is below twice the radix and fits in RW bits; one correction step suffices.
    assign q_times_r = {{RW{1'b0}}, prod_hi_reg[RW-1:0]} * {{RW{1'b0}}, radix_reg};
    assign rem_est   = quotient_reg[RW-1:0] - q_times_r[RW-1:0];
    assign rem_over  = (rem_est >= radix_reg);
    assign rem_fix   = rem_over ? (rem_est - radix_reg) : rem_est;
    assign q_new     = prod_hi_reg + {{(VW-1){1'b0}}, rem_over};

    assign count_inc = count_reg + CW'(1);
    assign count_dec = count_reg - CW'(1);
    assign rd_idx    = count_dec[IW-1:0];

    // Digit d selects byte d of the combined sixteen-symbol alphabet.
    assign symbol_table = {symbols_high_reg, symbols_low_reg};

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quotient_reg  <= '0;
            count_reg     <= '0;
            negative_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                quotient_reg <= magnitude;
                count_reg    <= '0;
                negative_reg <= value_u[VW-1];
            end
            else if (cmd.fix)
            begin
                quotient_reg <= q_new;
                count_reg    <= count_inc;
            end
            else if (cmd.push_digit)
            begin
                count_reg <= count_dec;
            end

            if (cmd.push_sign || cmd.push_digit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            radix_reg <= radix_eff;
            recip_reg <= sird_pkg::reciprocal(radix_eff);
        end
        if (cmd.mul)
        begin
            prod_hi_reg <= product[2*VW-1:VW];
        end
        if (cmd.fix)
        begin
            digit_store[count_reg[IW-1:0]] <= rem_fix[DW-1:0];
        end
        if (cmd.push_sign)
        begin
            out_symbol_reg <= sird_pkg::MINUS_SIGN;
            out_last_reg   <= 1'b0;
        end
        else if (cmd.push_digit)
        begin
            out_symbol_reg <= symbol_table[{digit_store[rd_idx], 3'b000} +: SW];
            out_last_reg   <= (count_reg == CW'(1));
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_symbol = out_symbol_reg;
    assign out_last   = out_last_reg;

    assign sts.q_next_zero   = (q_new == '0);
    assign sts.cnt_next_full = (count_inc == CW'(sird_pkg::MAX_DIGITS));
    assign sts.negative      = negative_reg;
    assign sts.last_digit    = (count_reg == CW'(1));
    assign sts.out_free      = out_free;

    `SIRD_ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0(cmd), "sird: overlapping commands")
    `SIRD_ASSERT_IMPL(a_rem_bound, cmd.fix, ({1'b0, rem_est} < {radix_reg, 1'b0}),
        "sird: quotient estimate off by more than one")
    `SIRD_ASSERT_IMPL(a_push_free, (cmd.push_sign || cmd.push_digit), out_free,
        "sird: symbol pushed over an untaken symbol")
    `SIRD_ASSERT_IMPL(a_emit_count, cmd.push_digit, (count_reg != '0),
        "sird: digit emitted with an empty store")

endmodule

@@ sv/signed_integer_to_radix_digits_core.sv @@
// ============================================================================
// Signed integer to radix digits
// Converts a signed 32-bit integer to symbols in radix 2..16, sign first.
// ============================================================================
//
//  Channel   Dir   Payload                 Transaction
//  number    in    value[31:0] signed      one integer
//  digits    out   symbol[7:0], last       one symbol, last on the final one
//  cfg       in    cfg_index[1:0], data    one register write, no handshake
//
// Division runs a load, then one reciprocal multiply and one correction per
// digit; emission then gives one symbol per cycle while the output register
// is free, with a minus sign first for a negative integer.
// A new integer is accepted once the final symbol sits in the output register.
// Emission stalls while the output register holds a symbol not yet taken.
// Reset clears control state and loads radix 10 and an all-zero alphabet.
//
module signed_integer_to_radix_digits_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    sird_value_if.sink                        number,
    sird_symbol_if.source                     digits,
    input  logic                              cfg_write,
    input  logic [sird_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sird_pkg::CFG_DATA_W-1:0]   cfg_data
);

    sird_pkg::cmd_t cmd;
    sird_pkg::sts_t sts;

    sird_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (number.valid),
        .in_ready (number.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sird_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .value      (number.value),
        .out_ready  (digits.ready),
        .out_valid  (digits.valid),
        .out_symbol (digits.symbol),
        .out_last   (digits.last),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

@@ tb/sv/tb.sv @@
// ============================================================================
// Testbench for the signed integer to radix digits converter
// Sends signed integers through the number channel and checks every symbol
// on the digits channel against an in-bench prediction of the text, across
// radix settings (clamped ones too), loaded alphabets, idle bursts on both
// channels and a long output stall that fills the block.
// ============================================================================
module tb;

    localparam int CLK_HALF    = 4;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [63:0] ASCII_LOW  = 64'h3736_3534_3332_3130;
    localparam logic [63:0] ASCII_HIGH = 64'h4645_4443_4241_3938;

    typedef struct packed {
        logic [sird_pkg::SYMBOL_W-1:0] symbol;
        logic                          last;
    } glyph_t;

    logic clk;
    logic rst_n;
    logic                             cfg_write;
    logic [sird_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sird_pkg::CFG_DATA_W-1:0]  cfg_data;

    sird_value_if  number_ch ();
    sird_symbol_if digits_ch ();

    signed_integer_to_radix_digits_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .number    (number_ch),
        .digits    (digits_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies used by the prediction.
    logic [sird_pkg::RADIX_W-1:0] radix_cfg;
    logic [63:0]                  alphabet_low;
    logic [63:0]                  alphabet_high;

    glyph_t pending_symbols[$];
    glyph_t expected_glyph;

    int error_count;
    int values_sent;
    int symbols_checked;
    int sink_hold_cycles;
    bit idle_on;

    always #CLK_HALF clk = ~clk;

    // Clamp the programmed radix into 2..16.
    function automatic logic [sird_pkg::RADIX_W-1:0] active_base();
        logic [sird_pkg::RADIX_W-1:0] b;
        b = radix_cfg;
        if (b < 5'd2)
        begin
            b = 5'd2;
        end
        else if (b > 5'd16)
        begin
            b = 5'd16;
        end
        return b;
    endfunction

    function automatic logic [sird_pkg::SYMBOL_W-1:0] alphabet_symbol(input logic [3:0] d);
        logic [sird_pkg::SYMBOL_W-1:0] s;
        if (d < 4'd8)
        begin
            s = alphabet_low[8*d +: 8];
        end
        else
        begin
            s = alphabet_high[8*(d-8) +: 8];
        end
        return s;
    endfunction

    // Works out the symbols for one integer and queues them, sign first.
    function automatic void predict_text(input logic [sird_pkg::VALUE_W-1:0] v);
        logic [sird_pkg::VALUE_W-1:0] mag;
        logic [sird_pkg::VALUE_W-1:0] base;
        logic [3:0]                   digs [sird_pkg::MAX_DIGITS];
        int                           cnt;
        glyph_t                       g;
        base = {27'd0, active_base()};
        mag  = v[sird_pkg::VALUE_W-1] ? (32'd0 - v) : v;
        cnt  = 0;
        if (mag == 32'd0)
        begin
            digs[0] = 4'd0;
            cnt = 1;
        end
        while (mag != 32'd0 && cnt < sird_pkg::MAX_DIGITS)
        begin
            digs[cnt] = 4'(mag % base);
            mag = mag / base;
            cnt++;
        end
        if (v[sird_pkg::VALUE_W-1])
        begin
            g.symbol = sird_pkg::MINUS_SIGN;
            g.last   = 1'b0;
            pending_symbols.push_back(g);
        end
        for (int i = cnt - 1; i >= 0; i--)
        begin
            g.symbol = alphabet_symbol(digs[i]);
            g.last   = (i == 0);
            pending_symbols.push_back(g);
        end
    endfunction

    // Integers of varied shape: full random, small, shifted random, near powers
    // of the radix and the extremes of the range, each negated half the time.
    function automatic logic [sird_pkg::VALUE_W-1:0] pick_value();
        logic [sird_pkg::VALUE_W-1:0] v;
        logic [sird_pkg::VALUE_W-1:0] p;
        logic [sird_pkg::VALUE_W-1:0] base;
        int                           n;
        base = {27'd0, active_base()};
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: v = $urandom_range(0, 300);
            3:
            begin
                p = 32'd1;
                n = $urandom_range(1, 31);
                repeat (n)
                begin
                    if (p <= 32'h7FFF_FFFF / base)
                    begin
                        p = p * base;
                    end
                end
                v = p + 32'($urandom_range(0, 2)) - 32'd1;
            end
            4:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'd0;
                    default: v = 32'd1;
                endcase
            end
            default: v = 32'($urandom) >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            v = 32'd0 - v;
        end
        return v;
    endfunction

    // Sends one integer; valid stays high afterwards unless a gap follows.
    task automatic send_value(input logic [sird_pkg::VALUE_W-1:0] v);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            number_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        number_ch.valid = 1'b1;
        number_ch.value = v;
        do
        begin
            @(posedge clk);
        end
        while (!number_ch.ready);
        predict_text(v);
        values_sent++;
    endtask

    // Lowers valid and waits until every queued symbol has been taken.
    task automatic wait_idle();
        @(negedge clk);
        number_ch.valid = 1'b0;
        while (pending_symbols.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sird_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            sird_pkg::REG_RADIX:        radix_cfg     = data[sird_pkg::RADIX_W-1:0];
            sird_pkg::REG_SYMBOLS_LOW:  alphabet_low  = data;
            sird_pkg::REG_SYMBOLS_HIGH: alphabet_high = data;
            default: ;
        endcase
    endtask

    // Upper bits of the radix write carry noise; only the low five count.
    task automatic set_radix(input logic [sird_pkg::RADIX_W-1:0] r);
        write_reg(sird_pkg::REG_RADIX, {32'($urandom), 27'($urandom), r});
    endtask

    task automatic load_alphabet(input logic [63:0] lo, input logic [63:0] hi);
        write_reg(sird_pkg::REG_SYMBOLS_LOW, lo);
        write_reg(sird_pkg::REG_SYMBOLS_HIGH, hi);
    endtask

    // The block comes out of reset in decimal with an all-zero alphabet.
    task automatic test_reset_state();
        send_value(32'd0);
        send_value(-32'sd5);
        send_value(32'h7FFF_FFFF);
        wait_idle();
    endtask

    task automatic test_range_extremes();
        load_alphabet(ASCII_LOW, ASCII_HIGH);
        set_radix(5'd10);
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        wait_idle();
        set_radix(5'd2);
        send_value(32'h8000_0000);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'd0);
        wait_idle();
        set_radix(5'd16);
        send_value(32'h8000_0000);
        send_value(32'h1234_5678);
        send_value(32'hFEDC_BA98);
        wait_idle();
    endtask

    // Settings outside 2..16 must behave as the nearest legal radix.
    task automatic test_radix_clamp();
        set_radix(5'd0);
        send_value(32'd5);
        wait_idle();
        set_radix(5'd1);
        send_value(-32'sd6);
        wait_idle();
        set_radix(5'd17);
        send_value(32'hFEDC_BA98);
        wait_idle();
        set_radix(5'd31);
        send_value(32'd255);
        wait_idle();
    endtask

    task automatic test_random_phases();
        logic [sird_pkg::RADIX_W-1:0] fixed_radix [6];
        logic [sird_pkg::RADIX_W-1:0] r;
        fixed_radix = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd10, 5'd17};
        for (int ph = 0; ph < 8; ph++)
        begin
            r = (ph < 6) ? fixed_radix[ph] : sird_pkg::RADIX_W'($urandom_range(0, 31));
            set_radix(r);
            case (ph % 3)
                0: load_alphabet(ASCII_LOW, ASCII_HIGH);
                1: load_alphabet({$urandom, $urandom}, {$urandom, $urandom});
                default: load_alphabet({64{1'b1}}, {$urandom, $urandom});
            endcase
            idle_on = (ph != 3);
            repeat (32) send_value(pick_value());
            wait_idle();
        end
        idle_on = 1'b1;
    endtask

    // The sink holds off for a long stretch while long binary numbers keep
    // coming, so the block must stall its input.
    task automatic test_output_stall();
        set_radix(5'd2);
        load_alphabet(ASCII_LOW, {64{1'b0}});
        idle_on = 1'b0;
        @(negedge clk);
        sink_hold_cycles = 400;
        repeat (12) send_value(32'h8000_0000 | 32'($urandom));
        wait_idle();
        idle_on = 1'b1;
    endtask

    task automatic test_streaming();
        set_radix(5'd10);
        load_alphabet(ASCII_LOW, ASCII_HIGH);
        idle_on = 1'b0;
        repeat (40) send_value(pick_value());
        wait_idle();
    endtask

    // Output sink: idle bursts, plus a long hold-off when one is requested.
    initial
    begin
        int burst;
        burst = 0;
        digits_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
            begin
                digits_ch.ready = 1'b0;
            end
            else if (sink_hold_cycles > 0)
            begin
                digits_ch.ready = 1'b0;
                sink_hold_cycles--;
            end
            else if (burst > 0)
            begin
                digits_ch.ready = 1'b0;
                burst--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                digits_ch.ready = 1'b0;
                burst = $urandom_range(1, 12) - 1;
            end
            else
            begin
                digits_ch.ready = 1'b1;
            end
        end
    end

    // Every symbol transaction is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && digits_ch.valid && digits_ch.ready)
        begin
            if (pending_symbols.size() == 0)
            begin
                error_count++;
                $display("%0t: symbol expected none actual %h last %b",
                         $time, digits_ch.symbol, digits_ch.last);
            end
            else
            begin
                expected_glyph = pending_symbols.pop_front();
                symbols_checked++;
                if (digits_ch.symbol !== expected_glyph.symbol)
                begin
                    error_count++;
                    $display("%0t: symbol expected %h actual %h", $time,
                             expected_glyph.symbol, digits_ch.symbol);
                end
                if (digits_ch.last !== expected_glyph.last)
                begin
                    error_count++;
                    $display("%0t: last expected %b actual %b", $time,
                             expected_glyph.last, digits_ch.last);
                end
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        number_ch.valid = 1'b0;
        number_ch.value = '0;
        radix_cfg     = sird_pkg::RADIX_RESET;
        alphabet_low  = '0;
        alphabet_high = '0;
        error_count = 0;
        values_sent = 0;
        symbols_checked = 0;
        sink_hold_cycles = 0;
        idle_on = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_range_extremes();
        test_radix_clamp();
        test_random_phases();
        test_output_stall();
        test_streaming();

        if (pending_symbols.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d symbols never arrived", $time, pending_symbols.size());
        end
        $display("Converted %0d integers into %0d checked symbols,", values_sent,
                 symbols_checked);
        $display("over radix 2..16 with clamped settings, idle bursts and a long output stall.");
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/sird_pkg.sv
sv/sird_if.sv
sv/sird_ctrl.sv
sv/sird_datapath.sv
sv/signed_integer_to_radix_digits_core.sv
tb/sv/tb.sv
